// File: src/mpe_pkg.sv
// mpe_pkg: constants, Barrett factor, state types and inter-module structs
// for the modular power engine. No dependencies.
`timescale 1ns / 1ps

package mpe_pkg;

  // Field widths
  localparam int unsigned VAL_W       = 30;
  localparam int unsigned EXP_BITS_DEF = 63;
  localparam int unsigned MUL_W       = 32;

  // Prime modulus and its Barrett factor floor(2^60 / M), worked out at elaboration
  localparam logic [VAL_W-1:0] PRIME_MOD    = 30'd998244353;
  localparam logic [63:0]      BARRETT_MU_W = (64'd1 << 60) / {34'd0, PRIME_MOD};
  localparam logic [30:0]      BARRETT_MU   = BARRETT_MU_W[30:0];

  // Exponent sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_ACC_WAIT,
    ST_SQ_WAIT
  } state_t;

  // Modular multiplier states
  typedef enum logic [2:0] {
    MM_IDLE,
    MM_MUL_P,
    MM_MUL_Q,
    MM_MUL_T,
    MM_SUB,
    MM_FIX
  } mm_state_t;

  // Request to the modular multiplier
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } mm_req_t;

  // Response from the modular multiplier
  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] result;
  } mm_rsp_t;

endpackage

// File: src/modular_power_engine_unit.sv
// Square-and-multiply from the lowest exponent bit up. Each squaring or multiply runs on
// the one shared Barrett multiplier. One item at a time; the next item is taken in the
// same cycle that the result is in the output register. Synchronous active-high reset
// clears the sequencer and output valid; data registers are not reset.
`timescale 1ns / 1ps

module modular_power_engine_unit #(
  parameter int unsigned EXP_BITS = mpe_pkg::EXP_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [mpe_pkg::VAL_W-1:0] base,
  input  logic [EXP_BITS-1:0]       exponent,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [mpe_pkg::VAL_W-1:0] power
);

  mpe_pkg::state_t st, st_next;

  logic [mpe_pkg::VAL_W-1:0] run, run_next;
  logic [mpe_pkg::VAL_W-1:0] acc, acc_next;
  logic [EXP_BITS-1:0]       exp_q, exp_q_next;
  logic                      out_valid_next;
  logic [mpe_pkg::VAL_W-1:0] power_next;
  logic [mpe_pkg::VAL_W-1:0] base_red;

  mpe_pkg::mm_req_t mm_req;
  mpe_pkg::mm_rsp_t mm_rsp;

  // Shared modular multiplier
  mpe_modmul u_modmul (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .rsp (mm_rsp)
  );

  // Base is below 2M, one subtract reduces it
  assign base_red = (base >= mpe_pkg::PRIME_MOD) ? (base - mpe_pkg::PRIME_MOD) : base;

  assign in_stall = (st != mpe_pkg::ST_IDLE);

  // Sequencer: one exponent bit per step, multiply for a set bit, then square
  always_comb begin
    st_next        = st;
    run_next       = run;
    acc_next       = acc;
    exp_q_next     = exp_q;
    out_valid_next = out_valid && out_stall;
    power_next     = power;
    mm_req.start   = 1'b0;
    mm_req.a       = exp_q[0] ? acc : run;
    mm_req.b       = run;
    case (st)
      mpe_pkg::ST_IDLE: begin
        if (in_valid) begin
          run_next   = base_red;
          acc_next   = mpe_pkg::VAL_W'(1);
          exp_q_next = exponent;
          st_next    = mpe_pkg::ST_STEP;
        end
      end
      mpe_pkg::ST_STEP: begin
        if (exp_q == '0) begin
          // no bits left: hand the item over once the output register is free
          if (!out_valid || !out_stall) begin
            out_valid_next = 1'b1;
            power_next     = acc;
            st_next        = mpe_pkg::ST_IDLE;
          end
        end else begin
          mm_req.start = 1'b1;
          st_next      = exp_q[0] ? mpe_pkg::ST_ACC_WAIT : mpe_pkg::ST_SQ_WAIT;
        end
      end
      mpe_pkg::ST_ACC_WAIT: begin
        if (mm_rsp.done) begin
          acc_next      = mm_rsp.result;
          exp_q_next[0] = 1'b0;
          st_next       = mpe_pkg::ST_STEP;
        end
      end
      mpe_pkg::ST_SQ_WAIT: begin
        if (mm_rsp.done) begin
          run_next   = mm_rsp.result;
          exp_q_next = exp_q >> 1;
          st_next    = mpe_pkg::ST_STEP;
        end
      end
      default: st_next = mpe_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= mpe_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      st        <= st_next;
      out_valid <= out_valid_next;
    end
  end

  // Data registers
  always_ff @(posedge clk) begin
    run   <= run_next;
    acc   <= acc_next;
    exp_q <= exp_q_next;
    power <= power_next;
  end

endmodule

// File: src/mpe_modmul.sv
// mpe_modmul: a*b mod 998244353 by Barrett reduction on one shared
// 32x32 multiplier. Depends on mpe_pkg.
`timescale 1ns / 1ps

module mpe_modmul (
  input  logic            clk,
  input  logic            rst,
  input  mpe_pkg::mm_req_t req,
  output mpe_pkg::mm_rsp_t rsp
);

  mpe_pkg::mm_state_t st, st_next;

  logic [mpe_pkg::VAL_W-1:0] a_op;
  logic [mpe_pkg::VAL_W-1:0] b_op;
  logic [63:0]               mul_q;
  logic [31:0]               p_lo;
  logic [31:0]               rem;

  logic [mpe_pkg::MUL_W-1:0] mul_x;
  logic [mpe_pkg::MUL_W-1:0] mul_y;
  logic [63:0]               mul_prod;
  logic [32:0]               rem_m1;
  logic [32:0]               rem_m2;

  // Operand select for the shared multiplier
  always_comb begin
    case (st)
      mpe_pkg::MM_MUL_P: begin
        mul_x = {2'b00, a_op};
        mul_y = {2'b00, b_op};
      end
      mpe_pkg::MM_MUL_Q: begin
        // q1 = P >> 29, times mu
        mul_x = {1'b0, mul_q[59:29]};
        mul_y = {1'b0, mpe_pkg::BARRETT_MU};
      end
      mpe_pkg::MM_MUL_T: begin
        // q3 = (q1 * mu) >> 31, times M
        mul_x = {1'b0, mul_q[61:31]};
        mul_y = {2'b00, mpe_pkg::PRIME_MOD};
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_prod = {32'd0, mul_x} * {32'd0, mul_y};

  // Final correction: remainder is below 3M
  assign rem_m1 = {1'b0, rem} - {3'b000, mpe_pkg::PRIME_MOD};
  assign rem_m2 = {1'b0, rem} - {2'b00, mpe_pkg::PRIME_MOD, 1'b0};

  always_comb begin
    rsp.done = (st == mpe_pkg::MM_FIX);
    if (!rem_m2[32]) begin
      rsp.result = rem_m2[mpe_pkg::VAL_W-1:0];
    end else if (!rem_m1[32]) begin
      rsp.result = rem_m1[mpe_pkg::VAL_W-1:0];
    end else begin
      rsp.result = rem[mpe_pkg::VAL_W-1:0];
    end
  end

  // Next state
  always_comb begin
    st_next = st;
    case (st)
      mpe_pkg::MM_IDLE:  if (req.start) st_next = mpe_pkg::MM_MUL_P;
      mpe_pkg::MM_MUL_P: st_next = mpe_pkg::MM_MUL_Q;
      mpe_pkg::MM_MUL_Q: st_next = mpe_pkg::MM_MUL_T;
      mpe_pkg::MM_MUL_T: st_next = mpe_pkg::MM_SUB;
      mpe_pkg::MM_SUB:   st_next = mpe_pkg::MM_FIX;
      mpe_pkg::MM_FIX:   st_next = mpe_pkg::MM_IDLE;
      default:           st_next = mpe_pkg::MM_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= mpe_pkg::MM_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (st == mpe_pkg::MM_IDLE && req.start) begin
      a_op <= req.a;
      b_op <= req.b;
    end
    if (st == mpe_pkg::MM_MUL_P || st == mpe_pkg::MM_MUL_Q || st == mpe_pkg::MM_MUL_T) begin
      mul_q <= mul_prod;
    end
    if (st == mpe_pkg::MM_MUL_Q) begin
      p_lo <= mul_q[31:0];
    end
    // r = P - q3*M fits in 32 bits, so low halves suffice
    if (st == mpe_pkg::MM_SUB) begin
      rem <= p_lo - mul_q[31:0];
    end
  end

endmodule

// File: src/mpe_checker.sv
// mpe_checker: port-level assertions for modular_power_engine_unit, bound
// to the top level below. Depends on mpe_pkg.
`timescale 1ns / 1ps

module mpe_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [mpe_pkg::VAL_W-1:0] power
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(power))
    else $error("stalled result changed");

  // Results are always reduced
  a_power_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> power < mpe_pkg::PRIME_MOD)
    else $error("result not reduced");

  // One item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // A new result only comes out of a busy engine
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without an item in flight");

  // Reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind modular_power_engine_unit mpe_checker u_mpe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .power     (power)
);

// File: verif/tb_modular_power_engine_unit.sv
// Self-checking testbench for modular_power_engine_unit: modular power mod 998244353.
// Depends on mpe_pkg and the RTL top level. The expected power is computed in the bench
// and compared in order with each result the block hands over.
`timescale 1ns / 1ps

module tb_modular_power_engine_unit;

  localparam int unsigned VW  = mpe_pkg::VAL_W;
  localparam int unsigned EW  = mpe_pkg::EXP_BITS_DEF;
  localparam logic [63:0] MODULUS = {34'd0, mpe_pkg::PRIME_MOD};
  localparam logic [VW-1:0] MOD_V = mpe_pkg::PRIME_MOD;
  localparam logic [EW-1:0] EXP_ONES = {EW{1'b1}};
  // worst case for one item, plus a margin
  localparam int unsigned DRAIN_CYCLES = 12 * EW - 5 + 50;
  localparam int unsigned HOLD_CYCLES  = 3000;

  typedef struct {
    logic [VW-1:0] base;
    logic [EW-1:0] exponent;
    logic [VW-1:0] power;
  } power_item_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [VW-1:0] base = '0;
  logic [EW-1:0] exponent = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [VW-1:0] power;

  power_item_t   expected_powers[$];
  int unsigned   mismatches = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  logic          holding = 1'b0;

  modular_power_engine_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .base      (base),
    .exponent  (exponent),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .power     (power)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Right-to-left square-and-multiply, base reduced first
  function automatic logic [VW-1:0] mod_power(input logic [VW-1:0] b, input logic [EW-1:0] e);
    logic [63:0] sq;
    logic [63:0] acc;
    sq  = {34'd0, b} % MODULUS;
    acc = 64'd1;
    for (int i = 0; i < EW; i++) begin
      if (e[i]) acc = (acc * sq) % MODULUS;
      sq = (sq * sq) % MODULUS;
    end
    return acc[VW-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Offer one item from a falling edge; returns on the falling edge after acceptance
  task automatic send_item(input logic [VW-1:0] b, input logic [EW-1:0] e);
    power_item_t item;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    base     <= b;
    exponent <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    item.base     = b;
    item.exponent = e;
    item.power    = mod_power(b, e);
    expected_powers.push_back(item);
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_powers.size() != 0) @(negedge clk);
  endtask

  function automatic logic [VW-1:0] random_base();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) return '0;
    if (pick < 4) return VW'(1);
    if (pick < 6) return MOD_V - VW'(1);
    // bases not yet reduced below the modulus
    if (pick < 13) return VW'($urandom_range(int'(MOD_V), (1 << VW) - 1));
    return VW'($urandom_range(0, int'(MOD_V) - 1));
  endfunction

  // Mostly short exponents to keep the run short, a third up to full width
  function automatic logic [EW-1:0] random_exponent();
    logic [63:0]   raw;
    logic [EW-1:0] mask;
    logic [EW-1:0] e;
    int unsigned   width;
    int unsigned   pick;
    raw  = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 4) return '0;
    if (pick < 70) width = $urandom_range(1, 16);
    else width = $urandom_range(17, EW);
    mask = EXP_ONES >> (EW - width);
    e = raw[EW-1:0] & mask;
    // dense and sparse patterns now and then
    if ($urandom_range(0, 9) == 0) e = mask;
    else if ($urandom_range(0, 9) == 0) e = '0;
    e[width-1] = 1'b1;
    return e;
  endfunction

  // Receiver stall, with a long hold-off when requested
  always @(negedge clk) begin
    out_stall <= holding || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin : check_results
    power_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_powers.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: power=%0d", power));
      end else begin
        want = expected_powers.pop_front();
        if (power !== want.power)
          report_mismatch($sformatf("base=%0d exponent=%0d: power=%0d, expected %0d",
                                    want.base, want.exponent, power, want.power));
      end
    end
  end

  // Extremes, exponent zero, unreduced bases, Fermat identities
  task automatic test_directed_corners();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item('0, '0);
    send_item('0, EW'(1));
    send_item('0, EXP_ONES);
    send_item(VW'(1), '0);
    send_item(VW'(1), EXP_ONES);
    send_item(VW'(7), EW'(1));
    send_item(MOD_V - VW'(1), EW'(1));
    send_item(MOD_V - VW'(1), EW'(2));
    send_item(MOD_V - VW'(1), EXP_ONES);
    send_item(MOD_V - VW'(1), EW'(1) << (EW - 1));
    send_item(VW'(2), EW'(62));
    send_item(VW'(3), EW'(MOD_V) - EW'(1));
    send_item(VW'(3), EW'(MOD_V) - EW'(2));
    send_item(MOD_V, EW'(5));
    send_item(MOD_V + VW'(1), EXP_ONES);
    send_item({VW{1'b1}}, EXP_ONES);
    send_item({VW{1'b1}}, '0);
    send_item(VW'(12345), EW'(1) << (EW - 1));
    send_item(VW'(30'h2AAAAAAA), EW'({(EW + 1) / 2{2'b01}}));
    send_item(VW'(30'h15555555), EW'(~{(EW + 1) / 2{2'b01}}));
    wait_results_drained();
  endtask

  task automatic test_random_items(input int unsigned count, input int unsigned send_pct,
                                   input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_item(random_base(), random_exponent());
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        @(posedge clk) holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end
      begin
        repeat (10) send_item(random_base(), EW'($urandom_range(0, 4095)));
      end
    join
    wait_results_drained();
  endtask

  // Sender pauses until every result is back, then resumes
  task automatic test_pause_until_drained();
    send_idle_pct = 10;
    recv_idle_pct = 30;
    repeat (4) begin
      repeat (5) send_item(random_base(), random_exponent());
      wait_results_drained();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_corners();
    test_random_items(450, 33, 65);
    test_random_items(450, 65, 33);
    test_random_items(450, 0, 0);
    test_output_hold_off();
    test_pause_until_drained();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("modular_power_engine_unit test passed");
    end else begin
      $display("modular_power_engine_unit test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100_000_000;
    $display("modular_power_engine_unit test failed");
    $finish;
  end

endmodule
